>>> hdl/date_time_difference_macros.svh
// ----------------------------------------------------------------------------
// date_time_difference_macros
// Assertion macros shared by the date/time difference RTL.
// ----------------------------------------------------------------------------
`ifndef DATE_TIME_DIFFERENCE_MACROS_SVH
`define DATE_TIME_DIFFERENCE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define DTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// Types and calendar helpers for the date/time difference block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

   // one timestamp
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } dtd_stamp_type;

   // request beat
   typedef struct packed {
      logic [13:0] first_year;
      logic [3:0]  first_month;
      logic [4:0]  first_day;
      logic [4:0]  first_hour;
      logic [5:0]  first_minute;
      logic [5:0]  first_second;
      logic [13:0] other_year;
      logic [3:0]  other_month;
      logic [4:0]  other_day;
      logic [4:0]  other_hour;
      logic [5:0]  other_minute;
      logic [5:0]  other_second;
   } dtd_req_type;

   // response beat
   typedef struct packed {
      logic [13:0] diff_years;
      logic [3:0]  diff_months;
      logic [4:0]  diff_days;
      logic [4:0]  diff_hours;
      logic [5:0]  diff_minutes;
      logic [5:0]  diff_seconds;
      logic        day_clamped;
   } dtd_rsp_type;

   // ordered pair handed from the compare stage to the borrow chain
   typedef struct packed {
      dtd_stamp_type later;
      dtd_stamp_type earlier;
      logic          later_leap;
   } dtd_ordered_type;

   localparam logic [15:0] RECIP_25    = 16'd41944;  // ceil(2^20 / 25)
   localparam int          RECIP_SHIFT = 20;

   // gregorian leap test; divisibility by 25 through a reciprocal multiply
   function automatic logic leap_year(input logic [13:0] y);
      logic [29:0] prod;
      logic [9:0]  quot;
      logic [13:0] back;
      logic        div25;
      begin
         prod  = {16'd0, y} * {14'd0, RECIP_25};
         quot  = prod[RECIP_SHIFT +: 10];
         back  = {quot, 4'd0} + {1'b0, quot, 3'd0} + {4'd0, quot};
         div25 = (back == y);
         leap_year = (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
      end
   endfunction

   // length of the month before month m; out-of-range months give 31
   function automatic logic [4:0] prev_month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      begin
         case (m)
            4'd3:    len = leap ? 5'd29 : 5'd28;
            4'd5:    len = 5'd30;
            4'd7:    len = 5'd30;
            4'd10:   len = 5'd30;
            4'd12:   len = 5'd30;
            default: len = 5'd31;
         endcase
         prev_month_len = len;
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/date_time_difference.sv
// ----------------------------------------------------------------------------
// date_time_difference
// Difference between two calendar timestamps, later minus earlier.
// ----------------------------------------------------------------------------
// One beat is taken per clock and one result leaves per clock while no
// stall is raised. A request beat lands in the input register, the
// compare and borrow chain work on it combinationally, and the result
// goes into the result register. The result register and the input
// register are separate slots, so a new request is taken while a finished
// result waits; req_stall rises only when both slots are full and
// rsp_stall is high. There is no configuration and no start-up sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "date_time_difference_macros.svh"

module date_time_difference
   import dtd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire dtd_req_type req_data,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output dtd_rsp_type rsp_data
);

   logic            in_valid_ff;
   logic            in_valid_in;
   dtd_req_type     in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   dtd_rsp_type     out_data_ff;
   logic            req_take;
   logic            out_load;
   dtd_ordered_type ordered;
   dtd_rsp_type     result;

   // handshake control
   assign out_load     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !out_load;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= result;
      end
   end

   // compare and select
   dtd_order u_order (
      .req     (in_data_ff),
      .ordered (ordered)
   );

   // borrow chain
   dtd_borrow u_borrow (
      .ordered (ordered),
      .rsp     (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   `DTD_ASSERT_NOW(a_stall_needs_full, clock, reset, req_stall, in_valid_ff, "stall with empty input slot")
   `DTD_ASSERT_NEXT(a_held_beat_kept, clock, reset, in_valid_ff && !out_load, in_valid_ff, "held beat lost")
   `DTD_ASSERT_NEXT(a_load_gives_valid, clock, reset, out_load, out_valid_ff, "loaded result not shown")
   `DTD_ASSERT_NOW(a_clamp_zero_days, clock, reset, out_valid_ff && out_data_ff.day_clamped, out_data_ff.diff_days == 5'd0, "clamped days not zero")

endmodule

`default_nettype wire

>>> hdl/dtd_order.sv
// ----------------------------------------------------------------------------
// dtd_order
// Orders the two timestamps of a beat and flags a leap year on the later one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtd_order
   import dtd_pkg::*;
(
   input  wire dtd_req_type     req,
   output dtd_ordered_type      ordered
);

   dtd_stamp_type first_stamp;
   dtd_stamp_type other_stamp;
   logic          first_less;

   // regroup the request into two stamps
   assign first_stamp = '{year: req.first_year, month: req.first_month,
                          day: req.first_day, hour: req.first_hour,
                          minute: req.first_minute, second: req.first_second};
   assign other_stamp = '{year: req.other_year, month: req.other_month,
                          day: req.other_day, hour: req.other_hour,
                          minute: req.other_minute, second: req.other_second};

   // field-by-field order is one compare over the packed stamps
   assign first_less = (first_stamp < other_stamp);

   // equal stamps keep the first as the later one
   always_comb begin
      ordered.later      = first_less ? other_stamp : first_stamp;
      ordered.earlier    = first_less ? first_stamp : other_stamp;
      ordered.later_leap = leap_year(ordered.later.year);
   end

endmodule

`default_nettype wire

>>> hdl/dtd_borrow.sv
// ----------------------------------------------------------------------------
// dtd_borrow
// Borrow chain from seconds up to years, with the single day borrow and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtd_borrow
   import dtd_pkg::*;
(
   input  wire dtd_ordered_type ordered,
   output dtd_rsp_type          rsp
);

   dtd_stamp_type hi;
   dtd_stamp_type lo;
   logic [6:0]    sec_d;
   logic [6:0]    min_d;
   logic [5:0]    hour_d;
   logic [5:0]    day_d;
   logic [6:0]    day_adj;
   logic [4:0]    month_d;
   logic [4:0]    day_len;

   assign hi = ordered.later;
   assign lo = ordered.earlier;
   assign day_len = prev_month_len(hi.month, ordered.later_leap);

   always_comb begin
      // seconds and minutes wrap at 60
      sec_d  = {1'b0, hi.second} - {1'b0, lo.second};
      min_d  = {1'b0, hi.minute} - {1'b0, lo.minute} - {6'd0, sec_d[6]};
      // hours wrap at 24
      hour_d = {1'b0, hi.hour} - {1'b0, lo.hour} - {5'd0, min_d[6]};
      // days take one month length, then clamp if still negative
      day_d   = {1'b0, hi.day} - {1'b0, lo.day} - {5'd0, hour_d[5]};
      day_adj = {day_d[5], day_d} + (day_d[5] ? {2'd0, day_len} : 7'd0);
      // months wrap at 12
      month_d = {1'b0, hi.month} - {1'b0, lo.month} - {4'd0, day_d[5]};

      rsp.diff_seconds = sec_d[5:0] + (sec_d[6] ? 6'd60 : 6'd0);
      rsp.diff_minutes = min_d[5:0] + (min_d[6] ? 6'd60 : 6'd0);
      rsp.diff_hours   = hour_d[4:0] + (hour_d[5] ? 5'd24 : 5'd0);
      rsp.day_clamped  = day_adj[6];
      rsp.diff_days    = day_adj[6] ? 5'd0 : day_adj[4:0];
      rsp.diff_months  = month_d[3:0] + (month_d[4] ? 4'd12 : 4'd0);
      rsp.diff_years   = hi.year - lo.year - {13'd0, month_d[4]};
   end

endmodule

`default_nettype wire
